>>> design/bmsd_pkg.sv
// Shared types, constants and the digit decode for the button mode selector.
// No dependencies; used by bmsd_out_if and every module in this folder.
package bmsd_pkg;

  localparam int unsigned DebounceW  = 10;
  localparam int unsigned LongPressW = 16;
  localparam int unsigned RefreshW   = 8;
  localparam int unsigned CfgIdxW    = 2;
  localparam int unsigned CfgDataW   = 16;
  localparam int unsigned SegW       = 7;
  localparam int unsigned DigW       = 2;
  localparam int unsigned BankW      = 3;
  localparam int unsigned PresetW    = 4;
  localparam int unsigned ActionW    = 2;

  localparam logic [DebounceW-1:0]  DebounceRst  = 10'd50;
  localparam logic [LongPressW-1:0] LongPressRst = 16'd500;
  localparam logic [RefreshW-1:0]   RefreshRst   = 8'd4;

  localparam logic [BankW-1:0]   BankLast    = 3'd5;
  localparam logic [PresetW-1:0] PresetLast  = 4'd8;
  localparam logic [PresetW-1:0] PresetFirst = 4'd1;

  localparam logic [DigW-1:0] DigLow  = 2'b01;
  localparam logic [DigW-1:0] DigHigh = 2'b10;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_DEBOUNCE   = 2'd0,
    CFG_LONG_PRESS = 2'd1,
    CFG_REFRESH    = 2'd2,
    CFG_COMMON_AN  = 2'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    PH_RELEASED = 2'd0,
    PH_PRESSED  = 2'd1,
    PH_HELD     = 2'd2
  } phase_e;

  typedef enum logic [ActionW-1:0] {
    ACT_NONE  = 2'd0,
    ACT_CLICK = 2'd1,
    ACT_LONG  = 2'd2
  } action_e;

  typedef struct packed {
    logic [DebounceW-1:0]  debounce_ms;
    logic [LongPressW-1:0] long_press_ms;
    logic [RefreshW-1:0]   refresh_ms;
    logic                  anode_mode;
  } cfg_t;

  typedef struct packed {
    logic [BankW-1:0]   bank;
    logic [PresetW-1:0] preset;
    action_e            action;
  } sel_t;

  // 0-9 decode, bit0 = a .. bit6 = g; blank above 9
  function automatic logic [SegW-1:0] glyph(input logic [3:0] num);
    logic [SegW-1:0] seg;
    case (num)
      4'd0:    seg = 7'h3F;
      4'd1:    seg = 7'h06;
      4'd2:    seg = 7'h5B;
      4'd3:    seg = 7'h4F;
      4'd4:    seg = 7'h66;
      4'd5:    seg = 7'h6D;
      4'd6:    seg = 7'h7D;
      4'd7:    seg = 7'h07;
      4'd8:    seg = 7'h7F;
      4'd9:    seg = 7'h6F;
      default: seg = 7'h00;
    endcase
    return seg;
  endfunction

endpackage

>>> design/bmsd_if.sv
// Valid/ready channel interfaces for button requests and display results.
// Depends on bmsd_pkg for field widths.
interface bmsd_in_if;
  logic valid;
  logic ready;
  logic button_level;

  modport source (output valid, output button_level, input ready);
  modport sink   (input valid, input button_level, output ready);
endinterface

interface bmsd_out_if import bmsd_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [SegW-1:0]    segments;
  logic [DigW-1:0]    digit_enables;
  logic [BankW-1:0]   bank_number;
  logic [PresetW-1:0] preset_number;
  logic [ActionW-1:0] user_action;

  modport source (output valid, output segments, output digit_enables, output bank_number,
                  output preset_number, output user_action, input ready);
  modport sink   (input valid, input segments, input digit_enables, input bank_number,
                  input preset_number, input user_action, output ready);
endinterface

>>> design/bmsd_button.sv
// Debounced button sampler, click / long-press state machine, bank and preset.
// Depends on bmsd_pkg.
module bmsd_button import bmsd_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic step_i,
  input  logic pressed_i,
  input  cfg_t cfg_i,
  output sel_t sel_o
);

  phase_e                phase_q, phase_d;
  logic [DebounceW-1:0]  sample_age_q, sample_age_d;
  logic [LongPressW-1:0] press_age_q, press_age_d;
  logic [BankW-1:0]      bank_q, bank_d;
  logic [PresetW-1:0]    preset_q, preset_d;
  action_e               action;
  logic                  press_start;
  logic                  sample;

  always_comb begin
    phase_d     = phase_q;
    action      = ACT_NONE;
    press_start = 1'b0;
    sample      = sample_age_q >= cfg_i.debounce_ms;

    if (sample) begin
      sample_age_d = '0;
      case (phase_q)
        PH_PRESSED: begin
          if (!pressed_i) begin
            phase_d = PH_RELEASED;
            action  = ACT_CLICK;
          end else if (press_age_q >= cfg_i.long_press_ms) begin
            phase_d = PH_HELD;
            action  = ACT_LONG;
          end
        end
        PH_HELD: begin
          if (!pressed_i) phase_d = PH_RELEASED;
        end
        default: begin
          if (pressed_i) begin
            phase_d     = PH_PRESSED;
            press_start = 1'b1;
          end
        end
      endcase
    end else begin
      sample_age_d = (&sample_age_q) ? sample_age_q : sample_age_q + 1'b1;
    end

    if (press_start)        press_age_d = '0;
    else if (&press_age_q)  press_age_d = press_age_q;
    else                    press_age_d = press_age_q + 1'b1;

    bank_d   = bank_q;
    preset_d = preset_q;
    case (action)
      ACT_CLICK: preset_d = (preset_q >= PresetLast) ? PresetFirst : preset_q + 1'b1;
      ACT_LONG:  bank_d   = (bank_q >= BankLast) ? '0 : bank_q + 1'b1;
      default:   ;
    endcase

    sel_o.bank   = bank_d;
    sel_o.preset = preset_d;
    sel_o.action = action;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_RELEASED;
      sample_age_q <= '0;
      press_age_q  <= '0;
      bank_q       <= '0;
      preset_q     <= PresetFirst;
    end else if (step_i) begin
      phase_q      <= phase_d;
      sample_age_q <= sample_age_d;
      press_age_q  <= press_age_d;
      bank_q       <= bank_d;
      preset_q     <= preset_d;
    end
  end

endmodule

>>> design/bmsd_display.sv
// Two-digit multiplexed seven-segment driver with latched pin levels.
// Depends on bmsd_pkg.
module bmsd_display import bmsd_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 step_i,
  input  cfg_t                 cfg_i,
  input  sel_t                 sel_i,
  output logic [SegW+DigW-1:0] pins_o
);

  logic [RefreshW-1:0]  refresh_age_q, refresh_age_d;
  logic                 showing_high_q, showing_high_d;
  logic [SegW+DigW-1:0] pins_q, pins_d;
  logic [SegW-1:0]      seg;
  logic [DigW-1:0]      dig;
  logic [3:0]           num;

  always_comb begin
    refresh_age_d  = refresh_age_q;
    showing_high_d = showing_high_q;
    pins_d         = pins_q;
    num            = '0;
    seg            = '0;
    dig            = '0;
    if (refresh_age_q >= cfg_i.refresh_ms) begin
      refresh_age_d  = '0;
      showing_high_d = ~showing_high_q;
      num = showing_high_d ? sel_i.preset : {1'b0, sel_i.bank};
      seg = glyph(num);
      dig = showing_high_d ? DigHigh : DigLow;
      // lit digit pulled low for common cathode, segments inverted for common anode
      if (cfg_i.anode_mode) seg = ~seg;
      else                  dig = ~dig;
      pins_d = {dig, seg};
    end else if (!(&refresh_age_q)) begin
      refresh_age_d = refresh_age_q + 1'b1;
    end
  end

  assign pins_o = pins_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      refresh_age_q  <= '0;
      showing_high_q <= 1'b0;
      pins_q         <= '0;
    end else if (step_i) begin
      refresh_age_q  <= refresh_age_d;
      showing_high_q <= showing_high_d;
      pins_q         <= pins_d;
    end
  end

endmodule

>>> design/button_mode_selector_display.sv
// Button mode selector with two-digit display. Each request is one millisecond
// tick carrying the raw, active-low button level; each request yields exactly one
// result: the latched segment and digit pin levels, the current bank (0..5, stepped
// by long presses) and preset (1..8, stepped by clicks), and the action seen on
// that tick. The button is sampled once more than debounce_ms ticks have passed;
// a long press fires once the hold exceeds long_press_ms; the digits alternate
// once more than refresh_ms ticks have passed, bank on the low digit and preset on
// the high. All age counters saturate. Pins read zero until the first refresh, and
// a change of the polarity register (anode_mode) shows at the next refresh.
// Throughput is one request per clock: the whole tick update is one pass of logic
// from the state registers into the result register, and the result register takes
// a new request whenever it is empty or being drained, and a result is valid in
// the cycle after its request is taken. Configuration writes are taken at any edge
// with cfg_we_i high and should only be made while idle.
module button_mode_selector_display import bmsd_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  bmsd_in_if.sink             req_i,
  bmsd_out_if.source          res_o
);

  cfg_t                 cfg_q;
  sel_t                 sel;
  logic [SegW+DigW-1:0] pins;
  logic                 step;
  logic                 out_valid_q;
  logic [SegW+DigW-1:0] pins_q;
  sel_t                 sel_q;

  // register file
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.debounce_ms   <= DebounceRst;
      cfg_q.long_press_ms <= LongPressRst;
      cfg_q.refresh_ms    <= RefreshRst;
      cfg_q.anode_mode    <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_DEBOUNCE:   cfg_q.debounce_ms   <= cfg_data_i[DebounceW-1:0];
        CFG_LONG_PRESS: cfg_q.long_press_ms <= cfg_data_i[LongPressW-1:0];
        CFG_REFRESH:    cfg_q.refresh_ms    <= cfg_data_i[RefreshW-1:0];
        CFG_COMMON_AN:  cfg_q.anode_mode    <= cfg_data_i[0];
        default:        ;
      endcase
    end
  end

  // a request is taken whenever the result register is free or draining
  assign req_i.ready = !out_valid_q || res_o.ready;
  assign step        = req_i.valid && req_i.ready;

  bmsd_button u_button (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (step),
    .pressed_i (!req_i.button_level),
    .cfg_i     (cfg_q),
    .sel_o     (sel)
  );

  // display sees the bank/preset after this tick's button update
  bmsd_display u_display (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .cfg_i  (cfg_q),
    .sel_i  (sel),
    .pins_o (pins)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step) begin
      out_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      pins_q <= pins;
      sel_q  <= sel;
    end
  end

  assign res_o.valid         = out_valid_q;
  assign res_o.segments      = pins_q[SegW-1:0];
  assign res_o.digit_enables = pins_q[SegW+DigW-1:SegW];
  assign res_o.bank_number   = sel_q.bank;
  assign res_o.preset_number = sel_q.preset;
  assign res_o.user_action   = sel_q.action;

endmodule

>>> bench/bmsd_checker.sv
// Checker for the button mode selector: watches the request and result channels and the
// register write port, predicts each display result and compares it field by field.
// Depends on bmsd_pkg and the channel interfaces in bmsd_if.
module bmsd_checker import bmsd_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  bmsd_in_if                  req,
  bmsd_out_if                 res,
  output int unsigned         mismatches,
  output int unsigned         outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  // own segment decode, a = bit0; blank above 9
  localparam logic [SegW-1:0] SegLut [16] = '{
    7'h3F, 7'h06, 7'h5B, 7'h4F, 7'h66, 7'h6D, 7'h7D, 7'h07,
    7'h7F, 7'h6F, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00
  };

  typedef struct packed {
    logic [SegW-1:0]    segments;
    logic [DigW-1:0]    digits;
    logic [BankW-1:0]   bank;
    logic [PresetW-1:0] preset;
    action_e            action;
  } display_t;

  cfg_t                  regs;
  phase_e                phase;
  logic [DebounceW-1:0]  sample_age;
  logic [LongPressW-1:0] press_age;
  logic [RefreshW-1:0]   refresh_age;
  logic                  showing_high;
  logic [BankW-1:0]      bank;
  logic [PresetW-1:0]    preset;
  logic [SegW-1:0]       seg_pins;
  logic [DigW-1:0]       dig_pins;

  display_t pending_displays [$];

  function automatic void clear_selector();
    regs.debounce_ms   = DebounceRst;
    regs.long_press_ms = LongPressRst;
    regs.refresh_ms    = RefreshRst;
    regs.anode_mode    = 1'b0;
    phase        = PH_RELEASED;
    sample_age   = '0;
    press_age    = '0;
    refresh_age  = '0;
    showing_high = 1'b0;
    bank         = '0;
    preset       = PresetFirst;
    seg_pins     = '0;
    dig_pins     = '0;
  endfunction

  // one tick: button first, then bank/preset, then the display refresh
  function automatic display_t step_selector(input logic level);
    display_t        r;
    logic            down;
    logic            started;
    action_e         act;
    logic [3:0]      num;
    logic [SegW-1:0] seg;
    logic [DigW-1:0] dig;
    down    = !level;
    started = 1'b0;
    act     = ACT_NONE;
    if (sample_age >= regs.debounce_ms) begin
      sample_age = '0;
      if (down && phase != PH_PRESSED && phase != PH_HELD) begin
        phase   = PH_PRESSED;
        started = 1'b1;
      end else if (!down && phase == PH_PRESSED) begin
        phase = PH_RELEASED;
        act   = ACT_CLICK;
      end else if (down && phase == PH_PRESSED && press_age >= regs.long_press_ms) begin
        phase = PH_HELD;
        act   = ACT_LONG;
      end else if (!down && phase == PH_HELD) begin
        phase = PH_RELEASED;
      end
    end else if (!(&sample_age)) begin
      sample_age = sample_age + 1'b1;
    end
    if (started) press_age = '0;
    else if (!(&press_age)) press_age = press_age + 1'b1;

    if (act == ACT_CLICK) preset = (preset >= PresetLast) ? PresetFirst : preset + 1'b1;
    else if (act == ACT_LONG) bank = (bank >= BankLast) ? '0 : bank + 1'b1;

    if (refresh_age >= regs.refresh_ms) begin
      refresh_age  = '0;
      showing_high = !showing_high;
      num = showing_high ? preset : 4'(bank);
      seg = SegLut[num];
      dig = showing_high ? DigHigh : DigLow;
      if (regs.anode_mode) seg = ~seg;
      else dig = ~dig;
      seg_pins = seg;
      dig_pins = dig;
    end else if (!(&refresh_age)) begin
      refresh_age = refresh_age + 1'b1;
    end

    r.segments = seg_pins;
    r.digits   = dig_pins;
    r.bank     = bank;
    r.preset   = preset;
    r.action   = act;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    $display("%0t ns: %s: got %0d, expected %0d", $time, what, got, want);
    mismatches++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    display_t want;
    if (!rst_ni) begin
      clear_selector();
      pending_displays.delete();
      mismatches  = 0;
      outstanding = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_index_i))
          CFG_DEBOUNCE:   regs.debounce_ms   = cfg_data_i[DebounceW-1:0];
          CFG_LONG_PRESS: regs.long_press_ms = cfg_data_i[LongPressW-1:0];
          CFG_REFRESH:    regs.refresh_ms    = cfg_data_i[RefreshW-1:0];
          CFG_COMMON_AN:  regs.anode_mode    = cfg_data_i[0];
          default: ;
        endcase
      end
      if (res.valid && res.ready) begin
        if (pending_displays.size() == 0) begin
          report_mismatch("result with no request outstanding", 1, 0);
        end else begin
          want = pending_displays.pop_front();
          if (res.segments !== want.segments)
            report_mismatch("segments", res.segments, want.segments);
          if (res.digit_enables !== want.digits)
            report_mismatch("digit_enables", res.digit_enables, want.digits);
          if (res.bank_number !== want.bank)
            report_mismatch("bank_number", res.bank_number, want.bank);
          if (res.preset_number !== want.preset)
            report_mismatch("preset_number", res.preset_number, want.preset);
          if (res.user_action !== want.action)
            report_mismatch("user_action", res.user_action, want.action);
        end
      end
      if (req.valid && req.ready) pending_displays.push_back(step_selector(req.button_level));
      outstanding = pending_displays.size();
    end
  end

endmodule

>>> bench/tb.sv
// Top of the button mode selector testbench: clock, reset, register writes,
// button requests, result back-pressure, watchdog and verdict.
// Depends on bmsd_pkg, bmsd_if, the block itself and bmsd_checker.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import bmsd_pkg::*;

  localparam int unsigned ClkPeriod  = 10;
  localparam int unsigned LongHold   = 300;   // receiver hold-off, in cycles
  localparam int unsigned QuietLimit = 3000;  // cycles with no handshake at all

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_index;
  logic [CfgDataW-1:0] cfg_data;

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  bit          stall_req     = 1'b0;
  int unsigned ticks_sent    = 0;
  // last values written, used only to shape press lengths
  int unsigned deb_set = DebounceRst;
  int unsigned lp_set  = LongPressRst;

  int unsigned chk_fails;
  int unsigned chk_outstanding;

  bmsd_in_if  req_if ();
  bmsd_out_if res_if ();

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  button_mode_selector_display DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .req_i       (req_if),
    .res_o       (res_if)
  );

  bmsd_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .req         (req_if),
    .res         (res_if),
    .mismatches  (chk_fails),
    .outstanding (chk_outstanding)
  );

  // One tick request. Random idle gaps come first; valid then stays high until
  // the request is taken, so back-to-back requests keep it high throughout.
  task automatic send_tick(input logic level);
    while ($urandom_range(99) < send_idle_pct) begin
      req_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    req_if.valid        <= 1'b1;
    req_if.button_level <= level;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    @(negedge clk_i);
    ticks_sent++;
  endtask

  // A run of one level; a pressed run now and then bounces for a single tick.
  task automatic send_run(input logic level, input int unsigned n);
    for (int unsigned i = 0; i < n; i++)
      send_tick((!level && $urandom_range(19) == 0) ? 1'b1 : level);
  endtask

  // Stop offering and wait for every outstanding result, plus a short margin
  // so nothing is in flight when the registers change.
  task automatic wait_idle();
    req_if.valid <= 1'b0;
    while (chk_outstanding != 0) @(negedge clk_i);
    repeat (2) @(negedge clk_i);
  endtask

  // cfg_we is left high across consecutive writes; apply_setting drops it.
  task automatic write_reg(input cfg_idx_e idx, input int unsigned data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CfgDataW'(data);
    @(negedge clk_i);
  endtask

  task automatic apply_setting(input int unsigned deb, input int unsigned lp,
                               input int unsigned rs, input int unsigned ca);
    write_reg(CFG_DEBOUNCE, deb);
    write_reg(CFG_LONG_PRESS, lp);
    write_reg(CFG_REFRESH, rs);
    write_reg(CFG_COMMON_AN, ca);
    cfg_we  <= 1'b0;
    deb_set = deb;
    lp_set  = lp;
  endtask

  // Mostly well-formed presses: a short hold gives a click, a hold past the
  // long-press time gives a long press. The rest is random level noise.
  task automatic button_activity(input int unsigned budget);
    int unsigned stop_at;
    int unsigned pace;
    int unsigned hold;
    stop_at = ticks_sent + budget;
    while (ticks_sent < stop_at) begin
      pace = deb_set + 1;
      if ($urandom_range(9) < 2) begin
        repeat ($urandom_range(1, 12)) send_tick(1'($urandom_range(1)));
      end else begin
        if ($urandom_range(2) == 0) hold = pace * (lp_set + $urandom_range(2, 4));
        else hold = pace * $urandom_range(1, 2);
        if (hold > 120) hold = $urandom_range(60, 120);
        send_run(1'b0, hold);
        hold = pace * $urandom_range(1, 3);
        send_run(1'b1, (hold > 60) ? 60 : hold);
      end
    end
  endtask

  // Receiver: random back-pressure, or a long hold-off when asked, so the
  // block's result register fills and its request side stalls.
  initial begin : receiver
    res_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (stall_req) begin
        res_if.ready <= 1'b0;
        repeat (LongHold) @(negedge clk_i);
        stall_req = 1'b0;
      end
      res_if.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Watchdog: ends the run once nothing has moved on either channel for too long.
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < QuietLimit) begin
      @(posedge clk_i);
      if (!rst_ni || (req_if.valid && req_if.ready) || (res_if.valid && res_if.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin : stimulus
    int unsigned budget;
    rst_ni              = 1'b0;
    cfg_we              = 1'b0;
    cfg_index           = CFG_DEBOUNCE;
    cfg_data            = '0;
    req_if.valid        = 1'b0;
    req_if.button_level = 1'b1;
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;

    // Reset settings: pins stay dark until the first refresh (the fifth tick).
    repeat (6) send_tick(1'b1);
    wait_idle();

    // Sample every tick, refresh every tick, long press after three ticks.
    apply_setting(0, 3, 0, 0);
    send_tick(1'b0);                  // press starts
    send_tick(1'b1);                  // short press released: click
    repeat (6) send_tick(1'b0);       // hold past the limit: one long press only
    send_tick(1'b1);                  // release from held: no action
    wait_idle();

    // All-zero timing with common anode: long press on the very next sample.
    apply_setting(0, 0, 0, 1);
    send_tick(1'b0);
    send_tick(1'b0);
    send_tick(1'b1);
    send_tick(1'b0);
    send_tick(1'b1);

    // Three idling regimes, three register settings each; low and high
    // extremes and an all-zero setting are among them.
    for (int s = 0; s < 9; s++) begin
      wait_idle();
      case (s / 3)
        0:       begin send_idle_pct = 15; recv_idle_pct = 66; end
        1:       begin send_idle_pct = 66; recv_idle_pct = 15; end
        default: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
      endcase
      case (s)
        0:       apply_setting(1, 1, 1, 0);
        4:       apply_setting(1023, 65535, 255, 1);
        8:       apply_setting(0, 0, 0, 0);
        default: apply_setting($urandom_range(0, 4), $urandom_range(1, 6),
                               $urandom_range(0, 6), $urandom_range(1));
      endcase
      // long refresh interval needs a longer stretch to toggle at all
      budget = (s == 4) ? 300 : 80;
      // receiver holds off while requests keep coming
      if (s == 6) stall_req = 1'b1;
      button_activity(budget);
    end

    wait_idle();
    repeat (4) @(negedge clk_i);
    if (chk_fails == 0 && chk_outstanding == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

>>> filelist.f
design/bmsd_pkg.sv
design/bmsd_if.sv
design/bmsd_button.sv
design/bmsd_display.sv
design/button_mode_selector_display.sv
bench/bmsd_checker.sv
bench/tb.sv
